### hw/rtl/rnsl_pkg.sv
// Shared types and constants for the ring nearest-entry lookup block.
// Used by the controller, the datapath and the top level.
package rnsl_pkg;

   localparam int ID_W      = 64;
   localparam int IDX_OUT_W = 10;
   localparam int FUNC_W    = 2;
   localparam int STATUS_W  = 2;

   localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_APPEND = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_ORDER = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DISPATCH,
      S_SEARCH,
      S_RIGHT,
      S_LEFT,
      S_PICK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic load;
      logic dispatch;
      logic search;
      logic rd_right;
      logic rd_left;
      logic pick;
      logic push;
   } cmd_type;

   typedef struct packed {
      logic lookup_multi;  // lookup on a table of two or more entries
      logic more;          // search interval not yet empty
      logic out_free;      // output register can take a result this cycle
   } stat_type;

endpackage

### hw/rtl/rnsl_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module rnsl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wr_data,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hw/rtl/rnsl_ctrl.sv
// Sequencer for the ring lookup: accepts a beat, steps the datapath through
// dispatch, binary search, neighbor reads and pick. Depends on rnsl_pkg.
module rnsl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  rnsl_pkg::stat_type stat,
   output rnsl_pkg::cmd_type  cmd
);
   import rnsl_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            state_in = stat.lookup_multi ? S_SEARCH : S_FINISH;
         end
         S_SEARCH: begin
            if (!stat.more) state_in = S_RIGHT;
         end
         S_RIGHT:  state_in = S_LEFT;
         S_LEFT:   state_in = S_PICK;
         S_PICK:   state_in = S_FINISH;
         S_FINISH: begin
            if (stat.out_free) state_in = S_IDLE;
         end
         default:  state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            // no beat is taken while reset is held
            req_tready = !reset;
            cmd.load   = req_tvalid && !reset;
         end
         S_DISPATCH: cmd.dispatch = 1'b1;
         S_SEARCH:   cmd.search   = 1'b1;
         S_RIGHT:    cmd.rd_right = 1'b1;
         S_LEFT:     cmd.rd_left  = 1'b1;
         S_PICK:     cmd.pick     = 1'b1;
         S_FINISH:   cmd.push     = stat.out_free;
         default:    cmd          = '0;
      endcase
   end

endmodule

### hw/rtl/rnsl_dp.sv
// Datapath of the ring lookup: table RAM, entry count, search bounds,
// neighbor distances and the output register. Depends on rnsl_pkg, rnsl_ram.
module rnsl_dp #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic [rnsl_pkg::FUNC_W-1:0]           in_func,
   input  logic [rnsl_pkg::ID_W-1:0]             in_entry_id,
   input  logic [rnsl_pkg::ID_W-1:0]             in_key_word0,
   input  logic [rnsl_pkg::ID_W-1:0]             in_key_word1,
   input  logic [rnsl_pkg::ID_W-1:0]             in_key_word2,
   input  logic [rnsl_pkg::ID_W-1:0]             in_key_word3,
   input  rnsl_pkg::cmd_type                     cmd,
   output rnsl_pkg::stat_type                    stat,
   input  logic                                  rsp_tready,
   output logic                                  rsp_tvalid,
   output logic                                  rsp_found,
   output logic [rnsl_pkg::ID_W-1:0]             rsp_nearest_id,
   output logic [rnsl_pkg::IDX_OUT_W-1:0]        rsp_swarm_index,
   output logic [rnsl_pkg::STATUS_W-1:0]         rsp_status
);
   import rnsl_pkg::*;

   localparam int AW = $clog2(MAX_ENTRIES);
   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int XW = (AW > IDX_OUT_W) ? AW : IDX_OUT_W;

   // item registers
   logic [FUNC_W-1:0] func_ff;
   logic [ID_W-1:0]   entry_ff;
   logic [ID_W-1:0]   pos_ff;

   // table state
   logic [CW-1:0]     count_ff, count_in;
   logic [ID_W-1:0]   last_ff;     // copy of the highest stored entry

   // search state
   logic [CW-1:0]     lo_ff, hi_ff, mid_ff;
   logic [AW-1:0]     right_ff, left_ff;
   logic [ID_W-1:0]   right_id_ff, left_id_ff;
   logic [ID_W-1:0]   dright_ff, dleft_ff;

   // staged result
   logic              res_found_ff;
   logic [ID_W-1:0]   res_id_ff;
   logic [XW-1:0]     res_idx_ff;
   logic [STATUS_W-1:0] res_status_ff;

   // output register
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [ID_W-1:0]      rsp_id_ff;
   logic [IDX_OUT_W-1:0] rsp_idx_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;

   // RAM port
   logic              ram_we;
   logic [AW-1:0]     ram_addr;
   logic [ID_W-1:0]   ram_rdata;

   // combinational search step
   logic              go_right;
   logic [CW-1:0]     lo_n, hi_n, mid_n;
   logic [AW-1:0]     right_n, left_n;
   logic              is_full, bad_order, append_ok;
   logic              single_hit;
   logic [STATUS_W-1:0] disp_status;

   rnsl_ram #(
      .WIDTH (ID_W),
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .addr    (ram_addr),
      .wr_data (entry_ff),
      .rd_data (ram_rdata)
   );

   always_comb begin
      // ram_rdata holds the entry at mid_ff during search
      go_right = ram_rdata < pos_ff;
      lo_n     = go_right ? (mid_ff + CW'(1)) : lo_ff;
      hi_n     = go_right ? hi_ff : mid_ff;
      mid_n    = lo_n + ((hi_n - lo_n) >> 1);
      right_n  = (lo_n == count_ff) ? '0 : lo_n[AW-1:0];
      // wrap left of index zero to the last entry
      left_n   = (right_ff == '0) ? AW'(count_ff - CW'(1)) : (right_ff - AW'(1));

      is_full   = count_ff == CW'(MAX_ENTRIES);
      bad_order = (count_ff != '0) && (entry_ff <= last_ff);
      append_ok = !is_full && !bad_order;

      // single entry: it sits at index zero and is also the last
      single_hit  = (func_ff == FUNC_LOOKUP) && (count_ff == CW'(1));
      disp_status = ST_OK;
      if (func_ff == FUNC_APPEND) begin
         if (is_full) begin
            disp_status = ST_FULL;
         end else if (bad_order) begin
            disp_status = ST_ORDER;
         end
      end

      ram_we   = cmd.dispatch && (func_ff == FUNC_APPEND) && append_ok;
      ram_addr = '0;
      if (cmd.dispatch) begin
         ram_addr = (func_ff == FUNC_APPEND) ? count_ff[AW-1:0]
                                             : AW'(count_ff >> 1);
      end else if (cmd.search) begin
         ram_addr = (lo_n < hi_n) ? mid_n[AW-1:0] : right_n;
      end else if (cmd.rd_right) begin
         ram_addr = left_n;
      end

      stat.lookup_multi = (func_ff == FUNC_LOOKUP) && (count_ff > CW'(1));
      stat.more         = lo_n < hi_n;
      stat.out_free     = !rsp_valid_ff || rsp_tready;
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.dispatch) begin
         unique case (func_ff)
            FUNC_CLEAR:  count_in = '0;
            FUNC_APPEND: if (append_ok) count_in = count_ff + CW'(1);
            default:     count_in = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff  <= in_func;
         entry_ff <= in_entry_id;
         pos_ff   <= in_key_word0 ^ in_key_word1 ^ in_key_word2 ^ in_key_word3;
      end

      if (cmd.dispatch) begin
         res_found_ff  <= single_hit;
         res_id_ff     <= single_hit ? last_ff : '0;
         res_idx_ff    <= '0;
         res_status_ff <= disp_status;
         if ((func_ff == FUNC_APPEND) && append_ok) begin
            last_ff <= entry_ff;
         end
         if (func_ff == FUNC_LOOKUP) begin
            lo_ff  <= '0;
            hi_ff  <= count_ff;
            mid_ff <= count_ff >> 1;
         end
      end

      if (cmd.search) begin
         lo_ff    <= lo_n;
         hi_ff    <= hi_n;
         mid_ff   <= mid_n;
         right_ff <= right_n;
      end

      if (cmd.rd_right) begin
         right_id_ff <= ram_rdata;
         dright_ff   <= ram_rdata - pos_ff;
         left_ff     <= left_n;
      end

      if (cmd.rd_left) begin
         left_id_ff <= ram_rdata;
         dleft_ff   <= pos_ff - ram_rdata;
      end

      if (cmd.pick) begin
         res_found_ff  <= 1'b1;
         res_status_ff <= ST_OK;
         // ties go to the left neighbor
         if (dright_ff < dleft_ff) begin
            res_id_ff  <= right_id_ff;
            res_idx_ff <= XW'(right_ff);
         end else begin
            res_id_ff  <= left_id_ff;
            res_idx_ff <= XW'(left_ff);
         end
      end

      if (cmd.push) begin
         rsp_found_ff  <= res_found_ff;
         rsp_id_ff     <= res_id_ff;
         rsp_idx_ff    <= res_idx_ff[IDX_OUT_W-1:0];
         rsp_status_ff <= res_status_ff;
      end
   end

   assign rsp_tvalid      = rsp_valid_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_nearest_id  = rsp_id_ff;
   assign rsp_swarm_index = rsp_idx_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

### hw/rtl/ring_nearest_swarm_lookup.sv
// Top level of the ring nearest-entry lookup: controller plus datapath.
// Depends on rnsl_pkg, rnsl_ctrl, rnsl_dp, rnsl_ram.
//
// Channel | dir | tdata (low bit up)                          | tuser
// req     | in  | entry_id, key_word0..key_word3 (320 bits)    | func
// rsp     | out | nearest_id, swarm_index, zero pad (80 bits)  | found, status
//
// Clear, append, unused codes and lookups on fewer than two entries go from accept
// through dispatch and finish to the output register.
// A lookup on two or more entries runs one binary-search step per cycle (one
// registered table read each, at most floor(log2(count)) + 1 steps), then reads
// the right and left neighbors and picks the nearer one for the output register.
// Reset empties the table (count to zero); table contents need no clearing.
// One beat is in flight at a time; a new beat is taken while a result waits,
// and its result stalls until the output register drains.
module ring_nearest_swarm_lookup #(
   parameter int MAX_ENTRIES = 1024
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [319:0] req_tdata,   // entry_id, key_word0, key_word1, key_word2, key_word3
   input  logic [1:0]   req_tuser,   // func
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [79:0]  rsp_tdata,   // nearest_id, swarm_index, 6 zero bits
   output logic [2:0]   rsp_tuser    // found, status
);
   import rnsl_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   logic                 found;
   logic [ID_W-1:0]      nearest_id;
   logic [IDX_OUT_W-1:0] swarm_index;
   logic [STATUS_W-1:0]  status;

   rnsl_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   rnsl_dp #(
      .MAX_ENTRIES (MAX_ENTRIES)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .in_func         (req_tuser),
      .in_entry_id     (req_tdata[63:0]),
      .in_key_word0    (req_tdata[127:64]),
      .in_key_word1    (req_tdata[191:128]),
      .in_key_word2    (req_tdata[255:192]),
      .in_key_word3    (req_tdata[319:256]),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_tready      (rsp_tready),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_found       (found),
      .rsp_nearest_id  (nearest_id),
      .rsp_swarm_index (swarm_index),
      .rsp_status      (status)
   );

   assign rsp_tdata = {6'd0, swarm_index, nearest_id};
   assign rsp_tuser = {status, found};

endmodule

### tb/tb_top.sv
// Self-checking testbench for ring_nearest_swarm_lookup: clears, appends, lookups, a deep
// table and out-of-order appends, over the req/rsp streams with random idling on both sides.
// Depends on rnsl_pkg and the ring_nearest_swarm_lookup RTL.
`timescale 1ns / 1ps

module tb_top;
   import rnsl_pkg::*;

   localparam int TABLE_DEPTH  = 1024;
   localparam int LARGE_FILL   = 150;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 24;
   localparam int RANDOM_BEATS = 200;
   localparam int REPORT_LIMIT = 10;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   // packed so that entry_id lands in the low bits of req_tdata
   typedef struct packed {
      logic [63:0] key_word3;
      logic [63:0] key_word2;
      logic [63:0] key_word1;
      logic [63:0] key_word0;
      logic [63:0] entry_id;
   } req_fields_type;

   typedef struct packed {
      logic                 found;
      logic [ID_W-1:0]      nearest_id;
      logic [IDX_OUT_W-1:0] swarm_index;
      logic [STATUS_W-1:0]  status;
   } rsp_fields_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [319:0] req_tdata = '0;   // entry_id, key_word0, key_word1, key_word2, key_word3
   logic [1:0]   req_tuser = '0;   // func
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [79:0]  rsp_tdata;        // nearest_id, swarm_index, 6 zero bits
   logic [2:0]   rsp_tuser;        // found, status

   // shadow copy of the ring table
   logic [63:0] ring_copy [TABLE_DEPTH];
   int          ring_fill = 0;

   rsp_fields_type swarm_expect_q [$];
   logic [63:0] plan_ids [$];

   int mismatches = 0;
   int results_seen = 0;
   int beats_sent = 0;
   int lookups_sent = 0;
   int lookup_hits = 0;
   int full_rejects = 0;
   int order_rejects = 0;
   int holds_done = 0;
   bit idle_on = 1'b1;
   bit hold_request = 1'b0;

   ring_nearest_swarm_lookup #(
      .MAX_ENTRIES(TABLE_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (!idle_on || roll < 60) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      if (roll < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // first entry at or above pos (wrapping) versus the one before it; ties go left
   function automatic int nearest_slot(logic [63:0] pos);
      int lo, hi, mid, right_slot, left_slot;
      logic [63:0] dist_right, dist_left;
      lo = 0;
      hi = ring_fill;
      while (lo < hi) begin
         mid = (lo + hi) / 2;
         if (ring_copy[mid] < pos) lo = mid + 1;
         else hi = mid;
      end
      right_slot = (lo >= ring_fill) ? 0 : lo;
      left_slot  = (right_slot == 0) ? ring_fill - 1 : right_slot - 1;
      dist_right = ring_copy[right_slot] - pos;
      dist_left  = pos - ring_copy[left_slot];
      return (dist_right < dist_left) ? right_slot : left_slot;
   endfunction

   function automatic rsp_fields_type predict_swarm(logic [1:0] func, req_fields_type f);
      rsp_fields_type r;
      int slot;
      r = '0;
      case (func)
         FUNC_CLEAR: ring_fill = 0;
         FUNC_APPEND: begin
            if (ring_fill >= TABLE_DEPTH)
               r.status = ST_FULL;
            else if (ring_fill > 0 && f.entry_id <= ring_copy[ring_fill-1])
               r.status = ST_ORDER;
            else begin
               ring_copy[ring_fill] = f.entry_id;
               ring_fill++;
            end
         end
         FUNC_LOOKUP: begin
            if (ring_fill > 0) begin
               slot = nearest_slot(f.key_word0 ^ f.key_word1 ^ f.key_word2 ^ f.key_word3);
               r.found       = 1'b1;
               r.nearest_id  = ring_copy[slot];
               r.swarm_index = slot[IDX_OUT_W-1:0];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic send_beat(logic [1:0] func, req_fields_type f);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= f;
      do @(posedge clock); while (!req_tready);
      swarm_expect_q.push_back(predict_swarm(func, f));
      beats_sent++;
      if (func == FUNC_LOOKUP) lookups_sent++;
   endtask

   task automatic send_clear();
      send_beat(FUNC_CLEAR, {rand64(), rand64(), rand64(), rand64(), rand64()});
   endtask

   task automatic send_unused();
      send_beat(FUNC_UNUSED, {rand64(), rand64(), rand64(), rand64(), rand64()});
   endtask

   task automatic send_append(logic [63:0] id);
      send_beat(FUNC_APPEND, {rand64(), rand64(), rand64(), rand64(), id});
   endtask

   // random key whose four words fold to pos
   task automatic send_lookup(logic [63:0] pos);
      req_fields_type f;
      f.entry_id  = rand64();
      f.key_word0 = rand64();
      f.key_word1 = rand64();
      f.key_word2 = rand64();
      f.key_word3 = pos ^ f.key_word0 ^ f.key_word1 ^ f.key_word2;
      send_beat(FUNC_LOOKUP, f);
   endtask

   task automatic wait_for_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (swarm_expect_q.size() != 0) @(posedge clock);
   endtask

   // ascending ids: spread over the ring, packed low, or packed against the top
   task automatic build_plan(int count, int shape);
      logic [63:0] step_max, id;
      plan_ids.delete();
      if (count == 0) return;
      case (shape)
         0: begin
            step_max = 64'hFFFF_FFFF_FFFF_FFFF / (count + 1);
            id = rand64() % step_max;
         end
         1: begin
            step_max = 16;
            id = rand64() >> 1;
         end
         default: begin
            step_max = 16;
            id = ~64'd0 - 17 * (count + 1) + $urandom_range(0, 15);
         end
      endcase
      plan_ids.push_back(id);
      for (int i = 1; i < count; i++) begin
         id = id + 1 + rand64() % step_max;
         plan_ids.push_back(id);
      end
   endtask

   // exact hits, off-by-one, midpoints (ties) and the wrap gap, plus plain random
   function automatic logic [63:0] pick_target();
      int n, i, roll;
      logic [63:0] a, b;
      n = plan_ids.size();
      roll = $urandom_range(0, 9);
      if (n == 0 || roll < 3) return rand64();
      i = $urandom_range(0, n - 1);
      if (roll < 5) return plan_ids[i];
      if (roll < 7) return plan_ids[i] + ($urandom_range(0, 1) ? 64'd1 : ~64'd0);
      a = plan_ids[i];
      b = (i == n - 1) ? plan_ids[0] : plan_ids[i+1];
      return a + ((b - a) >> 1) + $urandom_range(0, 1);
   endfunction

   task automatic send_noise();
      case ($urandom_range(0, 4))
         0, 1: send_unused();
         2: send_clear();
         default: send_append((plan_ids.size() != 0) ? plan_ids[0] : rand64());
      endcase
   endtask

   task automatic test_small_tables();
      send_lookup(rand64());                   // empty table
      send_unused();
      send_clear();
      send_append(64'd0);
      send_lookup(rand64());                   // single entry answers any key
      send_append(64'd0);                      // equal to last
      send_append(~64'd0);
      send_append(64'd5);                      // below last
      send_lookup(64'd0);
      send_lookup(64'h8000_0000_0000_0000);
      send_lookup(64'h7FFF_FFFF_FFFF_FFFF);
      send_clear();
      send_append(64'd100);
      send_append(64'd300);
      send_lookup(64'd200);                    // tie between neighbors
      send_lookup(64'd201);
      send_clear();
      send_append(64'd100);
      send_append(~64'd99);
      send_lookup(64'd0);                      // tie across the wrap
      send_lookup(~64'd0);                     // above the last entry
      send_beat(FUNC_LOOKUP, {5{~64'd0}});
      send_beat(FUNC_LOOKUP, {64'd0, 64'd0, 64'd0, ~64'd0, 64'd0});
      send_unused();                           // table must be left alone
      send_lookup(64'd150);
      wait_for_results();
   endtask

   // deep table built while the result side holds off, so the input stalls
   task automatic test_large_table();
      hold_request = 1'b1;
      send_clear();
      build_plan(LARGE_FILL, 0);
      foreach (plan_ids[i]) send_append(plan_ids[i]);
      send_append(plan_ids[LARGE_FILL-1]);     // equal to last
      send_append(64'd0);
      send_lookup(plan_ids[LARGE_FILL-1]);
      send_lookup(plan_ids[LARGE_FILL-1] + 1);
      send_lookup(plan_ids[0]);
      repeat (12) send_lookup(pick_target());
      wait_for_results();
   endtask

   task automatic test_random_traffic();
      int first_beat, episode, count, shape;
      first_beat = beats_sent;
      episode = 0;
      while (beats_sent - first_beat < RANDOM_BEATS) begin
         idle_on = ($urandom_range(0, 3) != 0);
         if (episode % 9 == 4) hold_request = 1'b1;
         if ($urandom_range(0, 9) != 0) send_clear();
         shape = $urandom_range(0, 9);
         if (shape == 0) count = $urandom_range(0, 1);
         else if (shape == 1) count = $urandom_range(30, 120);
         else count = $urandom_range(2, 16);
         build_plan(count, $urandom_range(0, 2));
         foreach (plan_ids[i]) begin
            if ($urandom_range(0, 19) == 0) send_noise();
            send_append(plan_ids[i]);
         end
         repeat ($urandom_range(4, 14)) begin
            if ($urandom_range(0, 14) == 0) send_noise();
            send_lookup(pick_target());
         end
         if (episode % 7 == 3) wait_for_results();
         episode++;
      end
      idle_on = 1'b1;
      wait_for_results();
   endtask

   task automatic note_mismatch(string what, logic [63:0] want, logic [63:0] got);
      if (mismatches < REPORT_LIMIT)
         $display("[%0t] %s mismatch: expected %h, got %h", $time, what, want, got);
      mismatches++;
   endtask

   task automatic check_result();
      rsp_fields_type want, got;
      got.found       = rsp_tuser[0];
      got.status      = rsp_tuser[2:1];
      got.nearest_id  = rsp_tdata[63:0];
      got.swarm_index = rsp_tdata[73:64];
      results_seen++;
      if (swarm_expect_q.size() == 0) begin
         note_mismatch("unexpected beat", 64'd0, got.nearest_id);
         return;
      end
      want = swarm_expect_q.pop_front();
      if (got.found !== want.found) note_mismatch("found", want.found, got.found);
      if (got.nearest_id !== want.nearest_id)
         note_mismatch("nearest_id", want.nearest_id, got.nearest_id);
      if (got.swarm_index !== want.swarm_index)
         note_mismatch("swarm_index", want.swarm_index, got.swarm_index);
      if (got.status !== want.status) note_mismatch("status", want.status, got.status);
      if (want.found) lookup_hits++;
      if (want.status == ST_FULL) full_rejects++;
      if (want.status == ST_ORDER) order_rejects++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result();
   end

   // result side: random back-pressure plus the occasional long hold-off
   initial begin : rsp_side
      int stall_left, held;
      stall_left = 0;
      while (reset) @(negedge clock);
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_tready <= 1'b0;
            for (held = 0; held < HOLD_CYCLES; held++) @(negedge clock);
            hold_request = 1'b0;
            holds_done++;
         end else if (!idle_on) begin
            rsp_tready <= 1'b1;
         end else if (stall_left > 0) begin
            rsp_tready <= 1'b0;
            stall_left--;
         end else begin
            rsp_tready <= 1'b1;
            stall_left = pick_gap();
         end
      end
   end

   initial begin
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_small_tables();
      test_large_table();
      test_random_traffic();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d beats: %0d lookups (%0d hits), %0d results checked",
               beats_sent, lookups_sent, lookup_hits, results_seen);
      $display("Rejected appends: %0d full, %0d out of order; long result hold-offs: %0d",
               full_rejects, order_rejects, holds_done);
      if (mismatches == 0 && swarm_expect_q.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Timed out with %0d results outstanding", swarm_expect_q.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
